// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Concurrent checks sampled on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression holds at every clock edge
`define DMSF_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("dmsf: assertion failed");

// consequent holds in the cycle the antecedent holds
`define DMSF_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dmsf: assertion failed");

`else

`define DMSF_ASSERT_ALWAYS(label, expr)
`define DMSF_ASSERT_IMPLY(label, ante, cons)

`endif

`endif

// ===== sv/dmsf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmsf_pkg
// Types and constants of the directional mean smoothing filter.
// ----------------------------------------------------------------------------
package dmsf_pkg;

	localparam int DAY_W    = 9;
	localparam int SECTORS  = 16;
	localparam int SEC_W    = 4;
	localparam int BOUND    = 10000;
	localparam int OFS_W    = 4;   // signed window offset, radius up to 7
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	// request modes
	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	// sector codes
	localparam logic [SEC_W-1:0] SEC_TOP        = 4'd0;
	localparam logic [SEC_W-1:0] SEC_BOTTOM     = 4'd1;
	localparam logic [SEC_W-1:0] SEC_LEFT       = 4'd2;
	localparam logic [SEC_W-1:0] SEC_RIGHT      = 4'd3;
	localparam logic [SEC_W-1:0] SEC_DIAG_UR    = 4'd4;
	localparam logic [SEC_W-1:0] SEC_DIAG_DL    = 4'd5;
	localparam logic [SEC_W-1:0] SEC_ANTI_UL    = 4'd6;
	localparam logic [SEC_W-1:0] SEC_ANTI_DR    = 4'd7;
	localparam logic [SEC_W-1:0] SEC_CONE_UP    = 4'd8;
	localparam logic [SEC_W-1:0] SEC_CONE_DOWN  = 4'd9;
	localparam logic [SEC_W-1:0] SEC_CONE_LEFT  = 4'd10;
	localparam logic [SEC_W-1:0] SEC_CONE_RIGHT = 4'd11;
	localparam logic [SEC_W-1:0] SEC_QUAD_UL    = 4'd12;
	localparam logic [SEC_W-1:0] SEC_QUAD_UR    = 4'd13;
	localparam logic [SEC_W-1:0] SEC_QUAD_DL    = 4'd14;

	typedef struct packed {
		logic             mode;
		logic [DAY_W-1:0] day_value;
		logic             burnt_flag;
	} in_t;

	typedef struct packed {
		logic [DAY_W-1:0] smoothed_day;
		logic             pixel_flagged;
		logic             frame_last;
	} out_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_CENTER,
		S_CWAIT,
		S_WIN,
		S_WDRAIN,
		S_EVAL,
		S_DIV,
		S_DIVW,
		S_OUT
	} state_t;

	// membership of offset (di, dj) in sector k
	function automatic logic in_sector(input logic [SEC_W-1:0] k,
		input logic signed [OFS_W-1:0] di, input logic signed [OFS_W-1:0] dj);
		logic [OFS_W-1:0] ai;
		logic [OFS_W-1:0] aj;
		logic signed [OFS_W:0] dsum;
		logic signed [OFS_W:0] ddif;
		logic res;
		ai = (di < 0) ? OFS_W'(-di) : OFS_W'(di);
		aj = (dj < 0) ? OFS_W'(-dj) : OFS_W'(dj);
		dsum = {di[OFS_W-1], di} + {dj[OFS_W-1], dj};
		ddif = {di[OFS_W-1], di} - {dj[OFS_W-1], dj};
		case (k)
			SEC_TOP:        res = (di <= 0);
			SEC_BOTTOM:     res = (di >= 0);
			SEC_LEFT:       res = (dj <= 0);
			SEC_RIGHT:      res = (dj >= 0);
			SEC_DIAG_UR:    res = (ddif <= 0);
			SEC_DIAG_DL:    res = (ddif >= 0);
			SEC_ANTI_UL:    res = (dsum <= 0);
			SEC_ANTI_DR:    res = (dsum >= 0);
			SEC_CONE_UP:    res = (di <= 0) && (ai >= aj);
			SEC_CONE_DOWN:  res = (di >= 0) && (ai >= aj);
			SEC_CONE_LEFT:  res = (dj <= 0) && (aj >= ai);
			SEC_CONE_RIGHT: res = (dj >= 0) && (aj >= ai);
			SEC_QUAD_UL:    res = (di <= 0) && (dj <= 0);
			SEC_QUAD_UR:    res = (di <= 0) && (dj >= 0);
			SEC_QUAD_DL:    res = (di >= 0) && (dj <= 0);
			default:        res = (di >= 0) && (dj >= 0);
		endcase
		return res;
	endfunction

endpackage

// ===== sv/dmsf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmsf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dmsf_div #(
	parameter int NUM_W = 16,
	parameter int DEN_W = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] q_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   shifted;
	logic             fits;

	// trial subtract of the shifted remainder
	assign shifted = {rem_q, q_q[NUM_W-1]};
	assign fits    = (shifted >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DEN_W'(shifted - {1'b0, den_q});
				q_q   <= {q_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= DEN_W'(shifted);
				q_q   <= {q_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = q_q;

endmodule

// ===== sv/directional_mean_smoothing_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// directional_mean_smoothing_filter
// Raster burn-day smoothing over 16 directional sectors of a square window.
// ----------------------------------------------------------------------------
// Pixels enter in row-major order and are written into a line store of
// 2*MAX_RADIUS+1 rows with one read port; results trail the input by r rows
// plus r pixels, and flush requests drain the tail of a frame. The block works
// on one request at a time. A flagged result takes one store read per window
// position, then the shared cross-multiply compare sector by sector, then,
// when a sector was chosen, a bit-serial divide for the rounded mean. The line
// store needs no clearing after reset. Writes to the radius, width or height
// register restart the frame.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module directional_mean_smoothing_filter #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_RADIUS = 3
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  dmsf_pkg::in_t                      in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output dmsf_pkg::out_t                     out_data,
	input  logic                               cfg_wr_en,
	input  logic [dmsf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dmsf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	localparam int DAY_W = dmsf_pkg::DAY_W;
	localparam int OFS_W = dmsf_pkg::OFS_W;
	localparam int SEC_W = dmsf_pkg::SEC_W;
	localparam int CDW   = dmsf_pkg::CFG_DATA_W;
	localparam int ROWS  = 2 * MAX_RADIUS + 1;
	localparam int DEPTH = ROWS * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int CA    = $clog2(MAX_WIDTH);
	localparam int SLW   = $clog2(ROWS);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int IW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int RW    = $clog2(MAX_RADIUS + 1);
	localparam int LGW   = $clog2(MAX_RADIUS * (MAX_WIDTH + 1) + 1);
	localparam int CMPW  = IW + LGW;
	localparam int CW    = $clog2(ROWS * ROWS);
	localparam int SW    = DAY_W + CW;
	localparam int D2W   = 2 * SW;
	localparam int SSW   = 2 * CW;
	localparam int PW    = D2W + SSW;
	localparam int NW    = SW + 1;
	localparam int DNW   = CW + 1;
	localparam int RST_W = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
	localparam int RST_H = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;
	localparam int RST_N = RST_W * RST_H;
	localparam int RST_LAG = RST_W + 1;

	// ---------------- configuration ----------------
	logic [1:0]     cfg_r_q;
	logic [CDW-1:0] cfg_w_q;
	logic [CDW-1:0] cfg_h_q;
	logic           cfg_hit;

	assign cfg_hit = cfg_wr_en && ((cfg_index == dmsf_pkg::REG_RADIUS) ||
		(cfg_index == dmsf_pkg::REG_WIDTH) || (cfg_index == dmsf_pkg::REG_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_r_q <= 2'd1;
			cfg_w_q <= CDW'(1024);
			cfg_h_q <= CDW'(1024);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				dmsf_pkg::REG_RADIUS: cfg_r_q <= cfg_wdata[1:0];
				dmsf_pkg::REG_WIDTH:  cfg_w_q <= cfg_wdata;
				dmsf_pkg::REG_HEIGHT: cfg_h_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// effective geometry, clipped to the build limits, with zero sizes taken as one
	logic [WW-1:0]      w_eff;
	logic [HW-1:0]      h_eff;
	logic [RW-1:0]      r_eff;
	logic [WW+HW-1:0]   n_full;
	logic [LGW-1:0]     lag_full;
	logic [IW-1:0]      n_q;
	logic [LGW-1:0]     lag_q;

	always_comb begin
		if (cfg_w_q == '0) w_eff = WW'(1);
		else if (cfg_w_q > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
		else w_eff = WW'(cfg_w_q);
		if (cfg_h_q == '0) h_eff = HW'(1);
		else if (cfg_h_q > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
		else h_eff = HW'(cfg_h_q);
		if (cfg_r_q > MAX_RADIUS) r_eff = RW'(MAX_RADIUS);
		else r_eff = RW'(cfg_r_q);
	end

	assign n_full   = (WW+HW)'(w_eff) * (WW+HW)'(h_eff);
	assign lag_full = LGW'(LGW'(r_eff) * LGW'(w_eff) + LGW'(r_eff));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= IW'(RST_N);
			lag_q <= LGW'(RST_LAG);
		end else begin
			n_q   <= IW'(n_full);
			lag_q <= lag_full;
		end
	end

	// ---------------- control state ----------------
	dmsf_pkg::state_t state_q, state_d;

	logic [WW-1:0]  in_col_q;
	logic [HW-1:0]  in_row_q;
	logic [SLW-1:0] in_slot_q;
	logic [IW-1:0]  recv_q;
	logic [WW-1:0]  out_col_q;
	logic [HW-1:0]  out_row_q;
	logic [SLW-1:0] out_slot_q;
	logic [IW-1:0]  out_idx_q;
	logic           mode_s1;

	logic           accept;
	logic           pix_accept;
	logic           restart_now;
	logic           frame_full;
	logic           go_emit;
	logic           out_load;
	logic           out_free;

	assign in_ready    = (state_q == dmsf_pkg::S_IDLE);
	assign accept      = in_valid && in_ready;
	assign pix_accept  = accept && (in_data.mode == dmsf_pkg::MODE_PIXEL);
	assign frame_full  = (recv_q == n_q);
	assign restart_now = frame_full;
	assign out_free    = !out_valid || out_ready;

	always_comb begin
		if (mode_s1 == dmsf_pkg::MODE_FLUSH)
			go_emit = frame_full && (out_idx_q < n_q);
		else
			go_emit = (out_idx_q < n_q) &&
				(CMPW'(out_idx_q) + CMPW'(lag_q) < CMPW'(recv_q));
	end

	// ---------------- line store ----------------
	logic [DAY_W:0]  store_mem [DEPTH];
	logic            store_we;
	logic [AW-1:0]   store_wa;
	logic [AW-1:0]   store_ra;
	logic [DAY_W:0]  rd_q;
	logic [SLW-1:0]  wr_slot;
	logic [WW-1:0]   wr_col;

	assign wr_slot  = restart_now ? '0 : in_slot_q;
	assign wr_col   = restart_now ? '0 : in_col_q;
	assign store_we = pix_accept;
	assign store_wa = AW'(wr_slot) * AW'(MAX_WIDTH) + AW'(CA'(wr_col));

	always_ff @(posedge clk) begin
		if (store_we) store_mem[store_wa] <= {in_data.burnt_flag, in_data.day_value};
		rd_q <= store_mem[store_ra];
	end

	// ---------------- position counters ----------------
	logic [WW-1:0] in_col_base;
	logic [HW-1:0] in_row_base;
	logic [IW-1:0] recv_base;

	assign in_col_base = restart_now ? '0 : in_col_q;
	assign in_row_base = restart_now ? '0 : in_row_q;
	assign recv_base   = restart_now ? '0 : recv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			recv_q     <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			out_idx_q  <= '0;
		end else if (cfg_hit) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			recv_q     <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			out_idx_q  <= '0;
		end else if (pix_accept) begin
			recv_q <= recv_base + IW'(1);
			if (restart_now) begin
				out_col_q  <= '0;
				out_row_q  <= '0;
				out_slot_q <= '0;
				out_idx_q  <= '0;
			end
			if (in_col_base + WW'(1) >= w_eff) begin
				in_col_q <= '0;
				if (in_row_base + HW'(1) >= h_eff) begin
					in_row_q  <= '0;
					in_slot_q <= '0;
				end else begin
					in_row_q  <= in_row_base + HW'(1);
					in_slot_q <= (wr_slot == SLW'(ROWS - 1)) ? '0 : wr_slot + SLW'(1);
				end
			end else begin
				in_col_q  <= in_col_base + WW'(1);
				in_row_q  <= in_row_base;
				in_slot_q <= wr_slot;
			end
		end else if (out_load) begin
			out_idx_q <= out_idx_q + IW'(1);
			if (out_col_q + WW'(1) >= w_eff) begin
				out_col_q  <= '0;
				out_row_q  <= out_row_q + HW'(1);
				out_slot_q <= (out_slot_q == SLW'(ROWS - 1)) ? '0 : out_slot_q + SLW'(1);
			end else begin
				out_col_q <= out_col_q + WW'(1);
			end
		end
	end

	// ---------------- window walk ----------------
	logic signed [OFS_W-1:0] di_q, dj_q;
	logic signed [OFS_W-1:0] r_s;
	logic [SLW-1:0]          win_slot_q;
	logic [SLW:0]            slot_start_raw;
	logic [SLW-1:0]          slot_start;
	logic signed [HW+1:0]    wrow;
	logic signed [WW+1:0]    wcol;
	logic                    pos_ok;
	logic                    m_vld_s1;
	logic signed [OFS_W-1:0] m_di_s1, m_dj_s1;
	logic [DAY_W-1:0]        c_q;
	logic                    flag_q;

	assign r_s            = $signed(OFS_W'(r_eff));
	assign slot_start_raw = (SLW+1)'(out_slot_q) + (SLW+1)'(ROWS) - (SLW+1)'(r_eff);
	assign slot_start     = (slot_start_raw >= (SLW+1)'(ROWS)) ?
		SLW'(slot_start_raw - (SLW+1)'(ROWS)) : SLW'(slot_start_raw);
	assign wrow   = $signed({2'b00, out_row_q}) + (HW+2)'(di_q);
	assign wcol   = $signed({2'b00, out_col_q}) + (WW+2)'(dj_q);
	assign pos_ok = (wrow >= 0) && (wrow < $signed({2'b00, h_eff})) &&
		(wcol >= 0) && (wcol < $signed({2'b00, w_eff})) && !((di_q == 0) && (dj_q == 0));

	// store read address
	always_comb begin
		if (state_q == dmsf_pkg::S_WIN)
			store_ra = AW'(win_slot_q) * AW'(MAX_WIDTH) + AW'(CA'(wcol));
		else
			store_ra = AW'(out_slot_q) * AW'(MAX_WIDTH) + AW'(CA'(out_col_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_s1 <= 1'b0;
		end else begin
			m_vld_s1 <= (state_q == dmsf_pkg::S_WIN) && pos_ok;
		end
	end

	always_ff @(posedge clk) begin
		m_di_s1 <= di_q;
		m_dj_s1 <= dj_q;
		if (state_q == dmsf_pkg::S_CWAIT) begin
			c_q        <= rd_q[DAY_W-1:0];
			flag_q     <= rd_q[DAY_W];
			di_q       <= -r_s;
			dj_q       <= -r_s;
			win_slot_q <= slot_start;
		end else if (state_q == dmsf_pkg::S_WIN) begin
			if (dj_q == r_s) begin
				dj_q <= -r_s;
				di_q <= di_q + OFS_W'(1);
				win_slot_q <= (win_slot_q == SLW'(ROWS - 1)) ? '0 : win_slot_q + SLW'(1);
			end else begin
				dj_q <= dj_q + OFS_W'(1);
			end
		end
	end

	// ---------------- sector accumulators ----------------
	logic [SW-1:0] sum_q [dmsf_pkg::SECTORS];
	logic [CW-1:0] cnt_q [dmsf_pkg::SECTORS];

	always_ff @(posedge clk) begin
		for (int k = 0; k < dmsf_pkg::SECTORS; k++) begin
			if (state_q == dmsf_pkg::S_CWAIT) begin
				sum_q[k] <= '0;
				cnt_q[k] <= '0;
			end else if (m_vld_s1 && rd_q[DAY_W] &&
				dmsf_pkg::in_sector(SEC_W'(k), m_di_s1, m_dj_s1)) begin
				sum_q[k] <= sum_q[k] + SW'(rd_q[DAY_W-1:0]);
				cnt_q[k] <= cnt_q[k] + CW'(1);
			end
		end
	end

	// sector compare, one sector at a time
	logic [SEC_W-1:0] k_q;
	logic [2:0]       step_q;
	logic [SW-1:0]    u_q, cs_q, d_q;
	logic [CW-1:0]    s_q;
	logic [D2W-1:0]   d2_q;
	logic [SSW-1:0]   ss_q;
	logic [PW-1:0]    lhs_q, rhs_q;
	logic [D2W-1:0]   bnum_q;
	logic [SSW-1:0]   bden_q;
	logic             best_vld_q;
	logic [SW-1:0]    best_u_q;
	logic [CW-1:0]    best_s_q;
	logic             eval_last;

	assign eval_last = (state_q == dmsf_pkg::S_EVAL) && (step_q == 3'd4) &&
		(k_q == SEC_W'(dmsf_pkg::SECTORS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q        <= '0;
			step_q     <= '0;
			bden_q     <= SSW'(1);
			bnum_q     <= D2W'(dmsf_pkg::BOUND);
			best_vld_q <= 1'b0;
		end else if (state_q == dmsf_pkg::S_WDRAIN) begin
			k_q        <= '0;
			step_q     <= '0;
			bden_q     <= SSW'(1);
			bnum_q     <= D2W'(dmsf_pkg::BOUND);
			best_vld_q <= 1'b0;
		end else if (state_q == dmsf_pkg::S_EVAL) begin
			if (step_q == 3'd4) begin
				step_q <= '0;
				k_q    <= k_q + SEC_W'(1);
				if ((s_q != '0) && (lhs_q < rhs_q)) begin
					best_vld_q <= 1'b1;
					bnum_q     <= d2_q;
					bden_q     <= ss_q;
				end
			end else begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == dmsf_pkg::S_EVAL) begin
			case (step_q)
				3'd0: begin
					u_q  <= sum_q[k_q];
					s_q  <= cnt_q[k_q];
					cs_q <= SW'(c_q) * SW'(cnt_q[k_q]);
				end
				3'd1: d_q <= (u_q >= cs_q) ? u_q - cs_q : cs_q - u_q;
				3'd2: begin
					d2_q <= D2W'(d_q) * D2W'(d_q);
					ss_q <= SSW'(s_q) * SSW'(s_q);
				end
				3'd3: begin
					lhs_q <= PW'(d2_q) * PW'(bden_q);
					rhs_q <= PW'(bnum_q) * PW'(ss_q);
				end
				default: begin
					if ((s_q != '0) && (lhs_q < rhs_q)) begin
						best_u_q <= u_q;
						best_s_q <= s_q;
					end
				end
			endcase
		end
	end

	// ---------------- rounded mean ----------------
	logic          div_start;
	logic          div_done;
	logic [NW-1:0] div_quo;

	assign div_start = (state_q == dmsf_pkg::S_DIV) && best_vld_q;

	dmsf_div #(
		.NUM_W(NW),
		.DEN_W(DNW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({best_u_q, 1'b0} + NW'(best_s_q)),
		.den    ({best_s_q, 1'b0}),
		.done   (div_done),
		.quo    (div_quo)
	);

	logic [DAY_W-1:0] res_q;

	always_ff @(posedge clk) begin
		if ((state_q == dmsf_pkg::S_CWAIT) && !rd_q[DAY_W])
			res_q <= rd_q[DAY_W-1:0];
		else if ((state_q == dmsf_pkg::S_DIV) && !best_vld_q)
			res_q <= c_q;
		else if ((state_q == dmsf_pkg::S_DIVW) && div_done)
			res_q <= DAY_W'(div_quo);
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dmsf_pkg::S_IDLE;
			mode_s1 <= dmsf_pkg::MODE_PIXEL;
		end else begin
			state_q <= state_d;
			if (accept) mode_s1 <= in_data.mode;
		end
	end

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		case (state_q)
			dmsf_pkg::S_IDLE:   if (accept) state_d = dmsf_pkg::S_DECIDE;
			dmsf_pkg::S_DECIDE: state_d = go_emit ? dmsf_pkg::S_CENTER : dmsf_pkg::S_IDLE;
			dmsf_pkg::S_CENTER: state_d = dmsf_pkg::S_CWAIT;
			dmsf_pkg::S_CWAIT:  state_d = rd_q[DAY_W] ? dmsf_pkg::S_WIN : dmsf_pkg::S_OUT;
			dmsf_pkg::S_WIN: begin
				if ((dj_q == r_s) && (di_q == r_s)) state_d = dmsf_pkg::S_WDRAIN;
			end
			dmsf_pkg::S_WDRAIN: state_d = dmsf_pkg::S_EVAL;
			dmsf_pkg::S_EVAL:   if (eval_last) state_d = dmsf_pkg::S_DIV;
			dmsf_pkg::S_DIV:    state_d = best_vld_q ? dmsf_pkg::S_DIVW : dmsf_pkg::S_OUT;
			dmsf_pkg::S_DIVW:   if (div_done) state_d = dmsf_pkg::S_OUT;
			dmsf_pkg::S_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = dmsf_pkg::S_IDLE;
				end
			end
			default: state_d = dmsf_pkg::S_IDLE;
		endcase
	end

	// ---------------- output register ----------------
	logic           out_valid_q;
	dmsf_pkg::out_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.smoothed_day  <= res_q;
			out_q.pixel_flagged <= flag_q;
			out_q.frame_last    <= (out_idx_q == n_q - IW'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ---------------- assertions ----------------
	`DMSF_ASSERT_ALWAYS(a_out_behind_in, out_idx_q <= recv_q)
	`DMSF_ASSERT_IMPLY(a_div_done_state, div_done, state_q == dmsf_pkg::S_DIVW)
	`DMSF_ASSERT_IMPLY(a_store_write_idle, store_we, state_q == dmsf_pkg::S_IDLE)
	`DMSF_ASSERT_ALWAYS(a_best_den_nonzero, bden_q != '0)

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the directional mean smoothing filter.
// ----------------------------------------------------------------------------
// Small frames are streamed through the filter under several radius and size
// settings, with random gaps on the request side and random stalls on the
// result side. A scoreboard model of the line store and the sector selection
// predicts the results beyond a short table of directed requests, which runs first.
// ----------------------------------------------------------------------------
module tb;

	localparam int MAXW     = 1024;
	localparam int MAXH     = 1024;
	localparam int MAXR     = 3;
	localparam int ROWS     = 2 * MAXR + 1;
	localparam int SETTLE   = 400;
	localparam int LIMIT    = 1500000;

	// index past the register list
	localparam logic [dmsf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	dmsf_pkg::in_t in_data;
	logic out_valid;
	logic out_ready;
	dmsf_pkg::out_t out_data;
	logic cfg_wr_en;
	logic [dmsf_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [dmsf_pkg::CFG_DATA_W-1:0] cfg_wdata;

	typedef struct packed {
		logic typed;
		logic has;
		dmsf_pkg::out_t want;
	} pend_t;

	typedef struct packed {
		dmsf_pkg::in_t req;
		logic has;
		dmsf_pkg::out_t want;
	} row_t;

	// shadow state of the filter
	logic [9:0] store_mirror [0:ROWS*MAXW-1];
	int unsigned radius_reg, width_reg, height_reg;
	int unsigned row_in, col_in, next_out;
	bit frame_done;

	dmsf_pkg::out_t smooth_q[$];
	pend_t pend_q[$];
	int errors;
	int cycles;
	bit calm;
	int stall;

	directional_mean_smoothing_filter DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int unsigned eff_w();
		if (width_reg == 0) return 1;
		return (width_reg > MAXW) ? MAXW : width_reg;
	endfunction

	function automatic int unsigned eff_h();
		if (height_reg == 0) return 1;
		return (height_reg > MAXH) ? MAXH : height_reg;
	endfunction

	function automatic int unsigned eff_r();
		return (radius_reg > MAXR) ? MAXR : radius_reg;
	endfunction

	function automatic int unsigned slot_of(int unsigned row, int unsigned col);
		return (row % ROWS) * MAXW + (col % MAXW);
	endfunction

	function automatic bit in_dir(logic [dmsf_pkg::SEC_W-1:0] k, int di, int dj);
		int ai;
		int aj;
		ai = (di < 0) ? -di : di;
		aj = (dj < 0) ? -dj : dj;
		case (k)
			dmsf_pkg::SEC_TOP:        return di <= 0;
			dmsf_pkg::SEC_BOTTOM:     return di >= 0;
			dmsf_pkg::SEC_LEFT:       return dj <= 0;
			dmsf_pkg::SEC_RIGHT:      return dj >= 0;
			dmsf_pkg::SEC_DIAG_UR:    return di <= dj;
			dmsf_pkg::SEC_DIAG_DL:    return di >= dj;
			dmsf_pkg::SEC_ANTI_UL:    return di <= -dj;
			dmsf_pkg::SEC_ANTI_DR:    return di >= -dj;
			dmsf_pkg::SEC_CONE_UP:    return di <= 0 && ai >= aj;
			dmsf_pkg::SEC_CONE_DOWN:  return di >= 0 && ai >= aj;
			dmsf_pkg::SEC_CONE_LEFT:  return dj <= 0 && aj >= ai;
			dmsf_pkg::SEC_CONE_RIGHT: return dj >= 0 && aj >= ai;
			dmsf_pkg::SEC_QUAD_UL:    return di <= 0 && dj <= 0;
			dmsf_pkg::SEC_QUAD_UR:    return di <= 0 && dj >= 0;
			dmsf_pkg::SEC_QUAD_DL:    return di >= 0 && dj <= 0;
			default:                  return di >= 0 && dj >= 0;
		endcase
	endfunction

	// smoothed value of the pixel at next_out; advances next_out
	function automatic dmsf_pkg::out_t smooth_next();
		int unsigned w, h, oi, oj, c, res;
		int r, row, col, best;
		logic [9:0] cen, e;
		longint unsigned sum [dmsf_pkg::SECTORS];
		longint unsigned cnt [dmsf_pkg::SECTORS];
		longint unsigned bnum, bden, s, u, cs, d, d2;
		dmsf_pkg::out_t o;
		w = eff_w();
		h = eff_h();
		r = eff_r();
		oi = next_out / w;
		oj = next_out % w;
		cen = store_mirror[slot_of(oi, oj)];
		c = cen[8:0];
		res = c;
		if (cen[9]) begin
			for (int k = 0; k < dmsf_pkg::SECTORS; k++) begin
				sum[k] = 0;
				cnt[k] = 0;
			end
			bnum = dmsf_pkg::BOUND;
			bden = 1;
			best = -1;
			for (int di = -r; di <= r; di++) begin
				for (int dj = -r; dj <= r; dj++) begin
					row = oi + di;
					col = oj + dj;
					if (di == 0 && dj == 0) continue;
					if (row < 0 || row >= h || col < 0 || col >= w) continue;
					e = store_mirror[slot_of(row, col)];
					if (!e[9]) continue;
					for (int k = 0; k < dmsf_pkg::SECTORS; k++) begin
						if (in_dir(dmsf_pkg::SEC_W'(k), di, dj)) begin
							sum[k] += e[8:0];
							cnt[k]++;
						end
					end
				end
			end
			// exact cross-multiplied compare, first closest sector wins
			for (int k = 0; k < dmsf_pkg::SECTORS; k++) begin
				s = cnt[k];
				u = sum[k];
				if (s == 0) continue;
				cs = c * s;
				d = (u >= cs) ? u - cs : cs - u;
				d2 = d * d;
				if (d2 * bden < bnum * s * s) begin
					best = k;
					bnum = d2;
					bden = s * s;
				end
			end
			if (best >= 0)
				res = (2 * sum[best] + cnt[best]) / (2 * cnt[best]);
		end
		o.smoothed_day = res[8:0];
		o.pixel_flagged = cen[9];
		o.frame_last = (next_out == w * h - 1);
		next_out++;
		return o;
	endfunction

	function automatic void restart_frame();
		row_in = 0;
		col_in = 0;
		next_out = 0;
		frame_done = 0;
	endfunction

	// one accepted request; returns 1 with the result when one is due
	function automatic bit filter_step(dmsf_pkg::in_t req, output dmsf_pkg::out_t o);
		int unsigned w, h, r, n, lag, got;
		w = eff_w();
		h = eff_h();
		r = eff_r();
		n = w * h;
		lag = r * w + r;
		o = '0;
		if (req.mode == dmsf_pkg::MODE_FLUSH) begin
			if (frame_done && next_out < n) begin
				o = smooth_next();
				return 1;
			end
			return 0;
		end
		if (frame_done) restart_frame();
		if (row_in >= h || col_in >= w) restart_frame();
		store_mirror[slot_of(row_in, col_in)] = {req.burnt_flag, req.day_value};
		col_in++;
		if (col_in >= w) begin
			col_in = 0;
			row_in++;
			if (row_in >= h) begin
				row_in = 0;
				frame_done = 1;
			end
		end
		got = frame_done ? n : row_in * w + col_in;
		if (next_out < n && next_out + lag < got) begin
			o = smooth_next();
			return 1;
		end
		return 0;
	endfunction

	// prediction at acceptance, result check and result-side stalls
	always @(posedge clk or negedge arst_n) begin
		dmsf_pkg::out_t o;
		dmsf_pkg::out_t exp_o;
		pend_t p;
		bit got;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall = 0;
		end else begin
			if (in_valid && in_ready) begin
				p = pend_q.pop_front();
				got = filter_step(in_data, o);
				if (p.typed) begin
					if (p.has) smooth_q.push_back(p.want);
				end else if (got) begin
					smooth_q.push_back(o);
				end
			end
			if (out_valid && out_ready) begin
				if (smooth_q.size() == 0) begin
					$error("unexpected result %p", out_data);
					errors++;
				end else begin
					exp_o = smooth_q.pop_front();
					if (out_data.smoothed_day !== exp_o.smoothed_day) begin
						$error("smoothed_day exp %0d got %0d",
							exp_o.smoothed_day, out_data.smoothed_day);
						errors++;
					end
					if (out_data.pixel_flagged !== exp_o.pixel_flagged) begin
						$error("pixel_flagged exp %0d got %0d",
							exp_o.pixel_flagged, out_data.pixel_flagged);
						errors++;
					end
					if (out_data.frame_last !== exp_o.frame_last) begin
						$error("frame_last exp %0d got %0d",
							exp_o.frame_last, out_data.frame_last);
						errors++;
					end
				end
				stall = calm ? 0 : $urandom_range(0, 10);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// run guard
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	task automatic cfg_write(logic [dmsf_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[dmsf_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			dmsf_pkg::REG_RADIUS: radius_reg = val & 32'h3;
			dmsf_pkg::REG_WIDTH:  width_reg = val & 32'h7FF;
			dmsf_pkg::REG_HEIGHT: height_reg = val & 32'h7FF;
			default: ;
		endcase
		if (idx == dmsf_pkg::REG_RADIUS || idx == dmsf_pkg::REG_WIDTH ||
			idx == dmsf_pkg::REG_HEIGHT)
			restart_frame();
	endtask

	task automatic send(dmsf_pkg::in_t req, pend_t p);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pend_q.push_back(p);
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_rand(logic mode, logic [8:0] day, logic flag);
		dmsf_pkg::in_t req;
		req.mode = mode;
		req.day_value = day;
		req.burnt_flag = flag;
		send(req, '0);
	endtask

	// drop valid and wait for the filter to go quiet
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (smooth_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic row_t mk(logic mode, logic [8:0] day, logic flag, logic has,
		logic [8:0] sd, logic pf, logic fl);
		row_t t;
		t.req.mode = mode;
		t.req.day_value = day;
		t.req.burnt_flag = flag;
		t.has = has;
		t.want.smoothed_day = sd;
		t.want.pixel_flagged = pf;
		t.want.frame_last = fl;
		return t;
	endfunction

	initial begin
		row_t single [6];
		row_t grid [14];
		pend_t p;
		int sent;
		int w, h, r, n, lag, base, spread, cut, flushes;
		logic [8:0] day;
		bit paused;
		errors = 0;
		cycles = 0;
		calm = 0;
		paused = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_wr_en = 1'b0;
		cfg_index = dmsf_pkg::REG_RADIUS;
		cfg_wdata = '0;
		radius_reg = 1;
		width_reg = 1024;
		height_reg = 1024;
		restart_frame();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single pixel frame: result only by flush, passes through unchanged
		single[0] = mk(dmsf_pkg::MODE_PIXEL, 9'd511, 1'b1, 1'b0, 9'd0, 1'b0, 1'b0);
		single[1] = mk(dmsf_pkg::MODE_FLUSH, 9'd0, 1'b0, 1'b1, 9'd511, 1'b1, 1'b1);
		single[2] = mk(dmsf_pkg::MODE_FLUSH, 9'd0, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0);
		single[3] = mk(dmsf_pkg::MODE_PIXEL, 9'd0, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0);
		single[4] = mk(dmsf_pkg::MODE_FLUSH, 9'd511, 1'b1, 1'b1, 9'd0, 1'b0, 1'b1);
		single[5] = mk(dmsf_pkg::MODE_FLUSH, 9'd0, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0);
		cfg_write(dmsf_pkg::REG_WIDTH, 1);
		cfg_write(dmsf_pkg::REG_HEIGHT, 1);
		foreach (single[i]) begin
			p.typed = 1'b1;
			p.has = single[i].has;
			p.want = single[i].want;
			send(single[i].req, p);
		end
		drain();

		// 3x3 frame at radius 1: extremes, ties, unflagged centres, early flush
		cfg_write(dmsf_pkg::REG_WIDTH, 3);
		cfg_write(dmsf_pkg::REG_HEIGHT, 3);
		grid[0]  = mk(dmsf_pkg::MODE_FLUSH, 9'd0, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0);
		grid[1]  = mk(dmsf_pkg::MODE_PIXEL, 9'd0, 1'b1, 1'b0, 9'd0, 1'b0, 1'b0);
		grid[2]  = mk(dmsf_pkg::MODE_PIXEL, 9'd511, 1'b1, 1'b0, 9'd0, 1'b0, 1'b0);
		grid[3]  = mk(dmsf_pkg::MODE_PIXEL, 9'd100, 1'b1, 1'b0, 9'd0, 1'b0, 1'b0);
		grid[4]  = mk(dmsf_pkg::MODE_PIXEL, 9'd300, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0);
		grid[5]  = mk(dmsf_pkg::MODE_PIXEL, 9'd101, 1'b1, 1'b0, 9'd0, 1'b0, 1'b0);
		grid[6]  = mk(dmsf_pkg::MODE_PIXEL, 9'd102, 1'b1, 1'b0, 9'd0, 1'b0, 1'b0);
		grid[7]  = mk(dmsf_pkg::MODE_PIXEL, 9'd99, 1'b1, 1'b0, 9'd0, 1'b0, 1'b0);
		grid[8]  = mk(dmsf_pkg::MODE_PIXEL, 9'd1, 1'b1, 1'b0, 9'd0, 1'b0, 1'b0);
		grid[9]  = mk(dmsf_pkg::MODE_PIXEL, 9'd256, 1'b1, 1'b0, 9'd0, 1'b0, 1'b0);
		grid[10] = mk(dmsf_pkg::MODE_FLUSH, 9'd0, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0);
		grid[11] = mk(dmsf_pkg::MODE_FLUSH, 9'd0, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0);
		grid[12] = mk(dmsf_pkg::MODE_FLUSH, 9'd0, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0);
		grid[13] = mk(dmsf_pkg::MODE_FLUSH, 9'd0, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0);
		foreach (grid[i]) send(grid[i].req, '0);
		send_rand(dmsf_pkg::MODE_FLUSH, 9'd0, 1'b0);
		drain();

		// saturating sizes and an unused register index
		cfg_write(dmsf_pkg::REG_RADIUS, 3);
		cfg_write(dmsf_pkg::REG_WIDTH, 2047);
		cfg_write(dmsf_pkg::REG_HEIGHT, 0);
		cfg_write(REG_UNUSED, 5);
		for (int i = 0; i < 5; i++)
			send_rand(dmsf_pkg::MODE_PIXEL, 9'($urandom), 1'($urandom));
		send_rand(dmsf_pkg::MODE_FLUSH, 9'd0, 1'b0);
		drain();
		cfg_write(dmsf_pkg::REG_WIDTH, 0);
		cfg_write(dmsf_pkg::REG_RADIUS, 0);
		for (int i = 0; i < 3; i++)
			send_rand(dmsf_pkg::MODE_PIXEL, 9'($urandom), 1'($urandom));
		send_rand(dmsf_pkg::MODE_FLUSH, 9'd0, 1'b0);
		drain();

		// random frames, every request counted
		sent = 0;
		while (sent < 850) begin
			calm = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 3);
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
			h = $urandom_range(1, 6);
			cfg_write(dmsf_pkg::REG_RADIUS, r);
			cfg_write(dmsf_pkg::REG_WIDTH, w);
			cfg_write(dmsf_pkg::REG_HEIGHT, h);
			for (int f = 0; f < $urandom_range(1, 2); f++) begin
				n = w * h;
				lag = r * w + r;
				base = $urandom_range(0, 511);
				spread = ($urandom_range(0, 4) == 0) ? 512 : $urandom_range(1, 120);
				cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n) : n;
				for (int i = 0; i < cut; i++) begin
					if (spread == 512)
						day = 9'($urandom);
					else
						day = 9'(base + $urandom_range(0, spread) - spread / 2);
					send_rand(dmsf_pkg::MODE_PIXEL, day, $urandom_range(0, 9) < 7);
					sent++;
					if ($urandom_range(0, 19) == 0) begin
						send_rand(dmsf_pkg::MODE_FLUSH, 9'($urandom), 1'($urandom));
						sent++;
					end
					if (!paused && i == cut / 2) begin
						paused = 1;
						in_valid <= 1'b0;
						@(posedge clk);
						while (smooth_q.size() != 0) @(posedge clk);
					end
				end
				// drain the tail, sometimes only part of it
				flushes = ($urandom_range(0, 5) == 0) ? $urandom_range(0, lag) : lag + 2;
				for (int i = 0; i < flushes; i++) begin
					send_rand(dmsf_pkg::MODE_FLUSH, 9'($urandom), 1'($urandom));
					sent++;
				end
			end
			drain();
		end

		// wait out the last results
		in_valid <= 1'b0;
		while (smooth_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/dmsf_pkg.sv
sv/dmsf_div.sv
sv/directional_mean_smoothing_filter.sv
tb/tb.sv
